@@ design/plp_pkg.sv @@
// shared types and constants for the positional list block
`default_nettype none

package plp_pkg;

    // list geometry and field widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;

    // operation codes
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // one request transaction
    typedef struct packed {
        t_cmd                     command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_req;

    // one result transaction
    typedef struct packed {
        t_status                  status;
        logic                     value_present;
        logic signed [DATA_W-1:0] result_value;
        logic [CNT_W-1:0]         entry_count;
        logic                     head_present;
        logic signed [DATA_W-1:0] head_value;
    } t_result;

endpackage

`default_nettype wire

@@ design/plp_if.sv @@
// request and result channel interfaces for the positional list block
`default_nettype none

interface plp_req_if;
    logic                              valid;
    logic                              ready;
    plp_pkg::t_cmd                     command;
    logic [plp_pkg::POS_W-1:0]         position;
    logic signed [plp_pkg::DATA_W-1:0] item_value;

    modport source (output valid, output command, output position, output item_value,
                    input ready);
    modport sink   (input valid, input command, input position, input item_value,
                    output ready);
endinterface

interface plp_rsp_if;
    logic                              valid;
    logic                              ready;
    plp_pkg::t_status                  status;
    logic                              value_present;
    logic signed [plp_pkg::DATA_W-1:0] result_value;
    logic [plp_pkg::CNT_W-1:0]         entry_count;
    logic                              head_present;
    logic signed [plp_pkg::DATA_W-1:0] head_value;

    modport source (output valid, output status, output value_present, output result_value,
                    output entry_count, output head_present, output head_value,
                    input ready);
    modport sink   (input valid, input status, input value_present, input result_value,
                    input entry_count, input head_present, input head_value,
                    output ready);
endinterface

`default_nettype wire

@@ design/plp_store.sv @@
// row of list cells with entry count, one insert or delete per fire
`default_nettype none

module plp_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  plp_pkg::t_req    i_req,
    output plp_pkg::t_result o_result
);
    import plp_pkg::*;

    logic signed [DATA_W-1:0] r_entries [CAPACITY];
    logic signed [DATA_W-1:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    t_status                  w_status;
    logic                     w_ok;
    logic                     w_present;
    logic signed [DATA_W-1:0] w_rval;
    logic [IDX_W-1:0]         w_succ_idx;

    // error checks, in the order the operation defines
    always_comb begin
        w_status = ST_OK;
        if (i_req.command == CMD_INSERT) begin
            priority if (i_req.position > r_count) begin
                w_status = ST_RANGE;
            end else if (r_count == CNT_W'(CAPACITY)) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_OK;
            end
        end else begin
            priority if (r_count == '0) begin
                w_status = ST_EMPTY;
            end else if (i_req.position >= r_count) begin
                w_status = ST_RANGE;
            end else begin
                w_status = ST_OK;
            end
        end
    end

    assign w_ok = (w_status == ST_OK);

    // each cell takes its lower neighbor, its upper neighbor, the new value or holds
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            n_entries[k] = r_entries[k];
            if (w_ok) begin
                if (i_req.command == CMD_INSERT) begin
                    if (CNT_W'(k) > i_req.position) begin
                        n_entries[k] = r_entries[(k == 0) ? 0 : k - 1];
                    end else if (CNT_W'(k) == i_req.position) begin
                        n_entries[k] = i_req.item_value;
                    end
                end else if (CNT_W'(k) >= i_req.position) begin
                    n_entries[k] = r_entries[(k == CAPACITY - 1) ? k : k + 1];
                end
            end
        end
    end

    // entry count update
    always_comb begin
        n_count = r_count;
        if (w_ok) begin
            if (i_req.command == CMD_INSERT) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // reported value: the inserted one, or the successor that moves down
    assign w_succ_idx = i_req.position[IDX_W-1:0] + IDX_W'(1);

    always_comb begin
        w_present = 1'b0;
        w_rval    = '0;
        if (w_ok) begin
            if (i_req.command == CMD_INSERT) begin
                w_present = 1'b1;
                w_rval    = i_req.item_value;
            end else if ((i_req.position + CNT_W'(1)) < r_count) begin
                w_present = 1'b1;
                w_rval    = r_entries[w_succ_idx];
            end
        end
    end

    // result of this operation
    always_comb begin
        o_result.status        = w_status;
        o_result.value_present = w_present;
        o_result.result_value  = w_rval;
        o_result.entry_count   = n_count;
        o_result.head_present  = (n_count != '0);
        o_result.head_value    = (n_count != '0) ? n_entries[0] : '0;
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    // cell registers
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int k = 0; k < CAPACITY; k++) begin
                r_entries[k] <= n_entries[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/positional_list_insert_delete.sv @@
// top level of the positional list block
`default_nettype none

// Ordered list of up to 16 signed 32-bit values held in a row of cells.
// Each request inserts a value at a position from 0 to the count, or deletes
// the entry at a position from 0 to count-1; errors leave the list unchanged
// and report a status. One request per clock is taken unless result backpressure
// stalls it; the request is held in the input register, and its result, computed
// in a single pass through the cell row's shift and compare logic, is held in the
// result register.
// Backpressure on the result channel stalls the request channel only when
// both registers are full. Cell contents have no reset; only the count does.
module positional_list_insert_delete (
    input  logic     i_clk,
    input  logic     i_rst_n,
    plp_req_if.sink  i_req,
    plp_rsp_if.source o_rsp
);
    import plp_pkg::*;

    t_req    r_req;
    logic    r_req_valid;
    t_result r_res;
    logic    r_res_valid;
    t_result w_result;
    logic    w_advance;
    logic    w_fire;

    // pipeline flow control
    assign w_advance   = !r_res_valid || o_rsp.ready;
    assign w_fire      = r_req_valid && w_advance;
    assign i_req.ready = !r_req_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_req_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.command    <= i_req.command;
            r_req.position   <= i_req.position;
            r_req.item_value <= i_req.item_value;
        end
    end

    // list cells and operation logic
    plp_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_req    (r_req),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_advance) begin
            r_res_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_result;
        end
    end

    // result channel
    assign o_rsp.valid         = r_res_valid;
    assign o_rsp.status        = r_res.status;
    assign o_rsp.value_present = r_res.value_present;
    assign o_rsp.result_value  = r_res.result_value;
    assign o_rsp.entry_count   = r_res.entry_count;
    assign o_rsp.head_present  = r_res.head_present;
    assign o_rsp.head_value    = r_res.head_value;

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res.entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

    // head flag follows the count
    a_head_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res.head_present == (r_res.entry_count != '0)))
        else $error("head flag disagrees with count");

    // a reported value only comes with a successful operation
    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.value_present) |-> (r_res.status == ST_OK))
        else $error("value reported on an error");

    // a held result is not overwritten while stalled
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !o_rsp.ready) |=> (r_res_valid && $stable(r_res)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the positional list block: request driver, list shadow and result checker
module tb_top;
    import plp_pkg::*;

    localparam int PHASE_ITEMS = 370;
    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_LIMIT = 2000;

    // shadow of the list contents and the queue of results still owed by the block
    class list_scoreboard;
        logic signed [DATA_W-1:0] shadow[CAPACITY];
        int                       shadow_count;
        t_result                  owed_results[$];
        int                       mismatches;
        int                       requests_seen;
        int                       results_seen;
        int                       status_hits[4];
        int                       full_hits;
        int                       empty_hits;

        // apply an accepted transaction to the shadow list and queue its result
        function void note_request(t_req r);
            t_result res;
            int      p;
            int      i;
            res = '0;
            p   = r.position;
            if (r.command == CMD_INSERT) begin
                // range check comes before the full check
                if (p > shadow_count) begin
                    res.status = ST_RANGE;
                end else if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > p; i--) shadow[i] = shadow[i-1];
                    shadow[p] = r.item_value;
                    shadow_count++;
                    res.value_present = 1'b1;
                    res.result_value  = r.item_value;
                end
            end else begin
                // empty check comes first
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p >= shadow_count) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = p; i + 1 < shadow_count; i++) shadow[i] = shadow[i+1];
                    shadow_count--;
                    // deleting the tail leaves no successor to report
                    if (p < shadow_count) begin
                        res.value_present = 1'b1;
                        res.result_value  = shadow[p];
                    end
                end
            end
            res.entry_count  = CNT_W'(shadow_count);
            res.head_present = (shadow_count > 0);
            res.head_value   = (shadow_count > 0) ? shadow[0] : '0;
            owed_results.push_back(res);
            requests_seen++;
            status_hits[res.status]++;
            if (shadow_count == CAPACITY) full_hits++;
            if (shadow_count == 0) empty_hits++;
        endfunction

        function void check_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // compare one result transaction with the oldest owed result
        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d count %0d",
                       got.status, got.entry_count);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("value_present", want.value_present, got.value_present);
            check_field("result_value", want.result_value, got.result_value);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("head_present", want.head_present, got.head_present);
            check_field("head_value", want.head_value, got.head_value);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    plp_req_if req_if ();
    plp_rsp_if rsp_if ();

    list_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    positional_list_insert_delete u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side ready: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.status        = rsp_if.status;
            got.value_present = rsp_if.value_present;
            got.result_value  = rsp_if.result_value;
            got.entry_count   = rsp_if.entry_count;
            got.head_present  = rsp_if.head_present;
            got.head_value    = rsp_if.head_value;
            sb.check_result(got);
        end
    end

    // offer one request transaction; valid stays high on return for a back-to-back follower
    task automatic send_item(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.command    <= r.command;
        req_if.position   <= r.position;
        req_if.item_value <= r.item_value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input t_cmd c, input int pos, input logic signed [DATA_W-1:0] v);
        t_req r;
        r.command    = c;
        r.position   = POS_W'(pos);
        r.item_value = v;
        send_item(r);
    endtask

    // drop valid, then switch idle and stall mix on a rising edge so the ready process sees it cleanly
    task automatic set_phase(input int idle_pct, input int stall_pct, input bit hold);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) hold_asks++;
        @(negedge i_clk);
    endtask

    // mostly legal positions, biased to the ends, with some out-of-range noise
    function automatic t_req random_item(input int insert_pct);
        t_req r;
        int   cnt;
        int   pick;
        cnt       = sb.shadow_count;
        r.command = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
        pick      = $urandom_range(99);
        if (pick < 12 || (r.command == CMD_DELETE && cnt == 0)) begin
            r.position = POS_W'($urandom_range(31));
        end else if (r.command == CMD_INSERT) begin
            if (pick < 30)      r.position = '0;
            else if (pick < 48) r.position = POS_W'(cnt);
            else                r.position = POS_W'($urandom_range(cnt));
        end else begin
            if (pick < 30)      r.position = '0;
            else if (pick < 48) r.position = POS_W'(cnt - 1);
            else                r.position = POS_W'($urandom_range(cnt - 1));
        end
        case ($urandom_range(9))
            0:       r.item_value = 32'h7fff_ffff;
            1:       r.item_value = 32'h8000_0000;
            2:       r.item_value = '0;
            3:       r.item_value = 32'hffff_ffff;
            default: r.item_value = $urandom;
        endcase
        return r;
    endfunction

    initial begin : stimulus
        int k;
        int ph;
        int pos;
        int insert_pct;
        int drain;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.command    = CMD_INSERT;
        req_if.position   = '0;
        req_if.item_value = '0;
        rsp_if.ready      = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list errors
        send_cmd(CMD_DELETE, 0, 1);
        send_cmd(CMD_DELETE, 31, 2);
        send_cmd(CMD_INSERT, 1, 5);
        // directed: inserts at head, tail and middle with extreme values
        send_cmd(CMD_INSERT, 0, 32'h7fff_ffff);
        send_cmd(CMD_INSERT, 1, 32'h8000_0000);
        send_cmd(CMD_INSERT, 0, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 2, 0);
        // directed: delete at count, delete of the tail, delete of the head
        send_cmd(CMD_DELETE, 4, 0);
        send_cmd(CMD_DELETE, 3, 0);
        send_cmd(CMD_DELETE, 0, 32'h1234_5678);
        // directed: fill to capacity
        for (k = 0; k < CAPACITY - 2; k++) begin
            case (k % 3)
                0:       pos = 0;
                1:       pos = sb.shadow_count;
                default: pos = sb.shadow_count / 2;
            endcase
            send_cmd(CMD_INSERT, pos, $urandom);
        end
        // directed: full list, range before full, tail delete, far position
        send_cmd(CMD_INSERT, CAPACITY, 7);
        send_cmd(CMD_INSERT, CAPACITY + 1, 8);
        send_cmd(CMD_DELETE, CAPACITY - 1, 0);
        send_cmd(CMD_DELETE, 31, 0);

        // random phases with different idle and stall mixes
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       set_phase(0, 0, 1'b1);
                1:       set_phase(84, 0, 1'b0);
                2:       set_phase(0, 84, 1'b0);
                default: set_phase(28, 28, 1'b1);
            endcase
            insert_pct = 50;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // drift between filling, draining and balanced traffic
                if (k % 40 == 0) begin
                    case ($urandom_range(2))
                        0:       insert_pct = 80;
                        1:       insert_pct = 20;
                        default: insert_pct = 50;
                    endcase
                end
                send_item(random_item(insert_pct));
            end
        end
        set_phase(0, 0, 1'b0);

        // drain
        drain = 0;
        while (sb.owed_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.owed_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.owed_results.size());
            sb.mismatches++;
        end

        $display("covered %0d requests and %0d results; ok/range/empty/full = %0d/%0d/%0d/%0d",
                 sb.requests_seen, sb.results_seen, sb.status_hits[ST_OK],
                 sb.status_hits[ST_RANGE], sb.status_hits[ST_EMPTY], sb.status_hits[ST_FULL]);
        $display("list left full %0d times and empty %0d times across four idle/stall mixes",
                 sb.full_hits, sb.empty_hits);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
